@@ design/gbn_pkg.sv @@
// Shared types, constants and codes for the Go-Back-N sender window.
package gbn_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int FRAME_W    = 16;
  localparam int CNT_W      = 17;
  localparam int WIN_W      = 7;
  localparam int EFF_W      = $clog2(MAX_WINDOW + 1);
  localparam int CLAMP_W    = (EFF_W > WIN_W) ? EFF_W : WIN_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_EXIT = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [FRAME_W-1:0] ack_number;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [FRAME_W-1:0] frame_number;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BURST,
    ST_NEW,
    ST_EXIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic finish;
    logic base_inc;
    logic resend;
    logic emit_burst;
    logic emit_new;
    logic emit_exit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       active;
    logic       ack_final;
    logic       ack_base;
    logic       start_empty;
    logic       resend_empty;
    logic       can_send;
    logic       burst_last;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ design/go_back_n_sender_core.sv @@
// Go-Back-N sender window: top level joining controller and datapath.
//
// Items arrive on in_valid/in_ready: a start command, an acknowledgement
// (with ack_number) or a receive timeout. Each item yields zero or more
// result transfers on out_valid/out_ready, one per frame to send or one
// exit marker; last marks the final result of an item.
// One item at a time: an item is taken in one state and decoded in the next,
// and its results leave at one per cycle while the receiver keeps up
// (n results, at most the window of 64).
// An acknowledgement of the window base or a timeout of an active transfer
// yields at most one new frame.
// The single output register sets that pace; when the receiver stalls the
// burst simply waits on it, and in_ready stays low until the last result of
// the item is loaded into the register.
// Configuration (frame_count index 0, window_size index 1) is written with
// cfg_write; a write also takes effect on an item in progress.
// Reset (synchronous, rst) returns the window to its start-up state: no
// transfer under way, frame_count and window_size both one, output empty.
module go_back_n_sender_core
  import gbn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAME_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbn_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_emit_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_burst, cmd.emit_new, cmd.emit_exit}))
    else $error("more than one result loaded in a cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_burst || cmd.emit_new || cmd.emit_exit) |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  a_exit_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_EXIT) |-> (out_data.frame_number == '0 && out_data.last))
    else $error("malformed exit marker");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in progress");

endmodule

@@ design/gbn_ctrl.sv @@
// Controller state machine: decodes one item and sequences its transfers.
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.command)
          CMD_START: state_next = sts.start_empty ? ST_IDLE : ST_BURST;
          CMD_ACK: begin
            if (!sts.active)        state_next = ST_IDLE;
            else if (sts.ack_final) state_next = ST_EXIT;
            else if (sts.ack_base)  state_next = ST_NEW;
            else                    state_next = sts.resend_empty ? ST_IDLE : ST_BURST;
          end
          CMD_TIMEOUT: state_next = sts.active ? ST_NEW : ST_IDLE;
          default:     state_next = ST_IDLE;
        endcase
      end
      ST_BURST: begin
        if (sts.out_free && sts.burst_last) state_next = ST_IDLE;
      end
      ST_NEW: begin
        if (!sts.can_send || sts.out_free) state_next = ST_IDLE;
      end
      ST_EXIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        unique case (sts.command)
          CMD_START: cmd.start = 1'b1;
          CMD_ACK: begin
            if (sts.active) begin
              if (sts.ack_final)     cmd.finish   = 1'b1;
              else if (sts.ack_base) cmd.base_inc = 1'b1;
              else                   cmd.resend   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_BURST: cmd.emit_burst = sts.out_free;
      ST_NEW:   cmd.emit_new   = sts.out_free && sts.can_send;
      ST_EXIT:  cmd.emit_exit  = sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/gbn_datapath.sv @@
// Datapath: configuration, window state, burst counter and output register.
module gbn_datapath
  import gbn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAME_W-1:0]   cfg_data,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts
);

  logic [FRAME_W-1:0] frame_count;
  logic [WIN_W-1:0]   window_size;
  logic [1:0]         command;
  logic [FRAME_W-1:0] ack_number;
  logic [CNT_W-1:0]   next_new_frame;
  logic [CNT_W-1:0]   window_base;
  logic [CNT_W-1:0]   window_top;
  logic               started;
  logic               finished;
  logic [CNT_W-1:0]   cur;
  logic [CNT_W-1:0]   lim;

  logic [CLAMP_W-1:0] ws_ext;
  logic [CLAMP_W-1:0] win_clamp;
  logic [CNT_W-1:0]   win;
  logic [CNT_W-1:0]   fc_ext;
  logic [CNT_W-1:0]   start_lim;
  logic [CNT_W-1:0]   base_plus_win;
  logic [CNT_W-1:0]   resend_lim;
  logic [CNT_W:0]     span;
  logic [CNT_W-1:0]   cur_inc;

  always_comb begin
    ws_ext = CLAMP_W'(window_size);
    if (ws_ext == '0)
      win_clamp = CLAMP_W'(1);
    else if (ws_ext > CLAMP_W'(MAX_WINDOW))
      win_clamp = CLAMP_W'(MAX_WINDOW);
    else
      win_clamp = ws_ext;
    win           = CNT_W'(win_clamp);
    fc_ext        = CNT_W'(frame_count);
    start_lim     = (fc_ext < win) ? fc_ext : win;
    base_plus_win = window_base + win;
    resend_lim    = (base_plus_win < fc_ext) ? base_plus_win : fc_ext;
    span          = {1'b0, window_top} - {1'b0, window_base};
    cur_inc       = cur + CNT_W'(1);
  end

  always_comb begin
    sts.command      = command;
    sts.active       = started && !finished;
    sts.ack_final    = (CNT_W'(ack_number) + CNT_W'(1)) == fc_ext;
    sts.ack_base     = CNT_W'(ack_number) == window_base;
    sts.start_empty  = frame_count == '0;
    sts.resend_empty = window_base >= fc_ext;
    sts.can_send     = (span != {1'b0, win - CNT_W'(1)}) && (next_new_frame < fc_ext);
    sts.burst_last   = cur_inc == lim;
    sts.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_W'(1);
      window_size <= WIN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_COUNT: frame_count <= cfg_data;
        REG_WINDOW_SIZE: window_size <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command    <= in_data.command;
      ack_number <= in_data.ack_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_new_frame <= '0;
      window_base    <= '0;
      window_top     <= '0;
      started        <= 1'b0;
      finished       <= 1'b0;
    end else begin
      if (cmd.start) begin
        next_new_frame <= start_lim;
        window_base    <= '0;
        window_top     <= win - CNT_W'(1);
        started        <= 1'b1;
        finished       <= 1'b0;
      end
      if (cmd.finish) finished <= 1'b1;
      if (cmd.base_inc) window_base <= window_base + CNT_W'(1);
      if (cmd.emit_new) begin
        next_new_frame <= next_new_frame + CNT_W'(1);
        window_top     <= window_top + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur <= '0;
      lim <= start_lim;
    end else if (cmd.resend) begin
      cur <= window_base;
      lim <= resend_lim;
    end else if (cmd.emit_burst) begin
      cur <= cur_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_burst || cmd.emit_new || cmd.emit_exit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_burst) begin
      out_data <= '{kind: KIND_SEND, frame_number: cur[FRAME_W-1:0],
                    last: sts.burst_last};
    end else if (cmd.emit_new) begin
      out_data <= '{kind: KIND_SEND, frame_number: next_new_frame[FRAME_W-1:0],
                    last: 1'b1};
    end else if (cmd.emit_exit) begin
      out_data <= '{kind: KIND_EXIT, frame_number: '0, last: 1'b1};
    end
  end

endmodule
